>>> hw/rtl/wfot_pkg.sv
// Shared constants and types for the waypoint Frenet offset translator.
// No dependencies; every other file of the block imports this package.
package wfot_pkg;

    localparam int MAX_POINTS = 64;
    localparam int AW         = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CW         = $clog2(MAX_POINTS + 1);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int CFG_IW     = 2;

    typedef logic [CFG_IW-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OFFSET_S  = 2'd0;
    localparam t_cfg_idx CFG_OFFSET_D  = 2'd1;
    localparam t_cfg_idx CFG_REF_INDEX = 2'd2;

    typedef struct packed {
        logic signed [31:0] offset_s;
        logic signed [31:0] offset_d;
        logic [5:0]         ref_index;
    } t_cfg;

    // One classified input beat: the point, where it is stored, and whether it ends the path.
    typedef struct packed {
        logic [31:0]   px;
        logic [31:0]   py;
        logic [31:0]   pz;
        logic          wr;
        logic [AW-1:0] addr;
        logic          last;
        logic [CW-1:0] n;
    } t_cmd;

endpackage

>>> hw/rtl/wfot_if.sv
// Handshake interfaces of the translator: point input, result output and register writes.
// Depends on wfot_pkg.
interface wfot_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        last_point;
    modport source (output valid, output px, output py, output pz, output last_point,
                    input ready);
    modport sink   (input valid, input px, input py, input pz, input last_point,
                    output ready);
endinterface

interface wfot_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] qz;
    logic        invalid;
    logic        last_result;
    modport source (output valid, output qx, output qy, output qz, output invalid,
                    output last_result, input ready);
    modport sink   (input valid, input qx, input qy, input qz, input invalid,
                    input last_result, output ready);
endinterface

interface wfot_cfg_if;
    import wfot_pkg::*;
    logic        valid;
    logic        ready;
    t_cfg_idx    idx;
    logic [31:0] wdata;
    modport source (output valid, output idx, output wdata, input ready);
    modport sink   (input valid, input idx, input wdata, output ready);
endinterface

>>> hw/rtl/wfot_front.sv
// Front end: accepts waypoint beats, assigns store slots and marks the end of a path.
// Depends on wfot_pkg and wfot_if.
module wfot_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wfot_pt_if.sink        i_pt,
    output wfot_pkg::t_cmd o_cmd,
    output logic           o_push,
    input  logic           i_full
);
    import wfot_pkg::*;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_wr;

    assign i_pt.ready = !i_full;
    assign o_push     = i_pt.valid && !i_full;

    // Points beyond the store size are dropped, but their end flag still counts.
    assign w_wr = (r_count < CW'(MAX_POINTS));

    always_comb begin
        o_cmd.px   = i_pt.px;
        o_cmd.py   = i_pt.py;
        o_cmd.pz   = i_pt.pz;
        o_cmd.wr   = w_wr;
        o_cmd.addr = r_count[AW-1:0];
        o_cmd.last = i_pt.last_point;
        o_cmd.n    = r_count + CW'(w_wr);
        n_count    = i_pt.last_point ? '0 : (r_count + CW'(w_wr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/wfot_fifo.sv
// Short command queue between the front end and the compute back end.
// Depends on wfot_pkg.
module wfot_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wfot_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output wfot_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import wfot_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

endmodule

>>> hw/rtl/wfot_back.sv
// Back end: point store, segment normalisation (shared multiplier, bit-serial square
// root and divider), offset scaling and result emission. Depends on wfot_pkg, wfot_if.
module wfot_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wfot_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    input  wfot_pkg::t_cfg i_cfg,
    wfot_res_if.source     o_res
);
    import wfot_pkg::*;

    localparam int RW = (CW + 1 > 7) ? CW + 1 : 7;
    localparam int OW = 36;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_DIFF, S_MAX, S_NORM, S_SQ_MUL, S_SQ_ACC, S_SQRT,
        S_DIV_INIT, S_DIV_STEP, S_SC_MUL, S_SC_ACC, S_EM_RD, S_EM_CAP, S_EM_OUT
    } t_state;

    function automatic logic [31:0] sat32(input logic signed [OW-1:0] v);
        logic [31:0] r;
        if (!v[OW-1] && (|v[OW-2:31])) begin
            r = 32'h7FFF_FFFF;
        end else if (v[OW-1] && !(&v[OW-2:31])) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [31:0] mem_x [MAX_POINTS];
    logic [31:0] mem_y [MAX_POINTS];
    logic [31:0] mem_z [MAX_POINTS];
    logic [31:0] r_rd_x, r_rd_y, r_rd_z;

    t_state             r_state;
    logic [CW-1:0]      r_n;
    logic [AW-1:0]      r_idx;
    logic [31:0]        r_ax, r_ay, r_az;
    logic [32:0]        r_m [3];
    logic               r_neg [3];
    logic [32:0]        r_mx;
    logic [63:0]        r_acc;
    logic [62:0]        r_prod;
    logic [2:0]         r_cnt;
    logic [63:0]        r_num;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_rem;
    logic [30:0]        r_nlo;
    logic [30:0]        r_q;
    logic [4:0]         r_dcnt;
    logic [30:0]        r_u [3];
    logic               r_tneg;
    logic signed [OW-1:0] r_o [3];
    logic [31:0]        r_qx, r_qy, r_qz;
    logic               r_inv, r_last, r_ovalid;

    logic [AW-1:0]      w_ra;
    logic [RW-1:0]      w_ref;
    logic               w_bad;
    logic signed [32:0] w_d [3];
    logic [32:0]        w_mag [3];
    logic [32:0]        w_mx;
    logic [31:0]        w_mul_a;
    logic [30:0]        w_mul_b;
    logic [62:0]        w_prod;
    logic [63:0]        w_sq_sum;
    logic [63:0]        w_rb;
    logic [31:0]        w_len;
    logic [61:0]        w_num;
    logic [32:0]        w_t;
    logic               w_ge;
    logic [31:0]        w_reg;
    logic [31:0]        w_reg_mag;
    logic [30:0]        w_usel;
    logic               w_uneg;
    logic [32:0]        w_r;
    logic signed [OW-1:0] w_term;
    logic               w_we;

    assign w_we      = (r_state == S_IDLE) && i_cmd_valid && i_cmd.wr;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign w_ref     = RW'(i_cfg.ref_index);
    assign w_bad     = (w_ref + RW'(2)) > RW'(i_cmd.n);
    assign w_len     = r_res[31:0];

    always_comb begin
        case (r_state)
            S_RD0:   w_ra = w_ref[AW-1:0];
            S_RD1:   w_ra = w_ref[AW-1:0] + 1'b1;
            default: w_ra = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[i_cmd.addr] <= i_cmd.px;
            mem_y[i_cmd.addr] <= i_cmd.py;
            mem_z[i_cmd.addr] <= i_cmd.pz;
        end
        r_rd_x <= mem_x[w_ra];
        r_rd_y <= mem_y[w_ra];
        r_rd_z <= mem_z[w_ra];
    end

    always_comb begin
        w_d[0] = $signed({r_rd_x[31], r_rd_x}) - $signed({r_ax[31], r_ax});
        w_d[1] = $signed({r_rd_y[31], r_rd_y}) - $signed({r_ay[31], r_ay});
        w_d[2] = $signed({r_rd_z[31], r_rd_z}) - $signed({r_az[31], r_az});
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = w_d[k][32] ? 33'(-w_d[k]) : 33'(w_d[k]);
        end
        w_mx = r_m[0];
        if (r_m[1] > w_mx) begin
            w_mx = r_m[1];
        end
        if (r_m[2] > w_mx) begin
            w_mx = r_m[2];
        end
    end

    // Term order of the offset sums: x gets s*ux and d*(-uy), y gets s*uy and d*ux,
    // z gets s*uz and d*uz.
    always_comb begin
        w_reg     = r_cnt[0] ? i_cfg.offset_d : i_cfg.offset_s;
        w_reg_mag = w_reg[31] ? 32'(-w_reg) : w_reg;
        case (r_cnt)
            3'd0:    begin w_usel = r_u[0]; w_uneg = r_neg[0];  end
            3'd1:    begin w_usel = r_u[1]; w_uneg = !r_neg[1]; end
            3'd2:    begin w_usel = r_u[1]; w_uneg = r_neg[1];  end
            3'd3:    begin w_usel = r_u[0]; w_uneg = r_neg[0];  end
            default: begin w_usel = r_u[2]; w_uneg = r_neg[2];  end
        endcase
        if (r_state == S_SQ_MUL) begin
            w_mul_a = {1'b0, r_m[r_cnt[1:0]][30:0]};
            w_mul_b = r_m[r_cnt[1:0]][30:0];
        end else begin
            w_mul_a = w_reg_mag;
            w_mul_b = w_usel;
        end
        w_prod   = 63'(w_mul_a) * 63'(w_mul_b);
        w_sq_sum = r_acc + 64'(r_prod);
        w_rb     = r_res + r_bit;
        w_num    = 62'({r_m[r_cnt[1:0]][30:0], 30'b0}) + 62'(w_len[31:1]);
        w_t      = {r_rem, r_nlo[30]};
        w_ge     = (w_t >= {1'b0, w_len});
        w_r      = 33'((r_prod + 63'(64'd1 << 29)) >> 30);
        w_term   = r_tneg ? -$signed(OW'(w_r)) : $signed(OW'(w_r));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.last) begin
                        r_n <= i_cmd.n;
                        if (w_bad) begin
                            r_qx     <= '0;
                            r_qy     <= '0;
                            r_qz     <= '0;
                            r_inv    <= 1'b1;
                            r_last   <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_state  <= S_EM_OUT;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_ax    <= r_rd_x;
                    r_ay    <= r_rd_y;
                    r_az    <= r_rd_z;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_m[k]   <= w_mag[k];
                        r_neg[k] <= w_d[k][32];
                    end
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    r_mx  <= w_mx;
                    r_acc <= '0;
                    r_cnt <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_o[k] <= '0;
                    end
                    if (w_mx == '0) begin
                        // A zero-length segment leaves a zero direction and zero offsets.
                        for (int k = 0; k < 3; k++) begin
                            r_u[k] <= '0;
                        end
                        r_state <= S_SC_MUL;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // One bit a cycle until the largest magnitude lies in [2^30, 2^31).
                    if (r_mx[32:31] != 2'b00) begin
                        r_mx <= r_mx >> 1;
                        for (int k = 0; k < 3; k++) begin
                            r_m[k] <= r_m[k] >> 1;
                        end
                    end else if (!r_mx[30]) begin
                        r_mx <= r_mx << 1;
                        for (int k = 0; k < 3; k++) begin
                            r_m[k] <= r_m[k] << 1;
                        end
                    end else begin
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_SQ_ACC;
                end
                S_SQ_ACC: begin
                    r_acc <= w_sq_sum;
                    if (r_cnt == 3'd2) begin
                        r_cnt   <= '0;
                        r_num   <= w_sq_sum;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT: begin
                    if (r_num >= w_rb) begin
                        r_num <= r_num - w_rb;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    // The upper part of the rounded numerator is already below the length.
                    r_rem   <= 32'(w_num[61:31]);
                    r_nlo   <= w_num[30:0];
                    r_dcnt  <= '0;
                    r_state <= S_DIV_STEP;
                end
                S_DIV_STEP: begin
                    r_rem  <= w_ge ? 32'(w_t - {1'b0, w_len}) : w_t[31:0];
                    r_nlo  <= r_nlo << 1;
                    r_q    <= {r_q[29:0], w_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'd30) begin
                        r_u[r_cnt[1:0]] <= {r_q[29:0], w_ge};
                        if (r_cnt == 3'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_SC_MUL;
                        end else begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_state <= S_DIV_INIT;
                        end
                    end
                end
                S_SC_MUL: begin
                    r_prod  <= w_prod;
                    r_tneg  <= w_reg[31] ^ w_uneg;
                    r_state <= S_SC_ACC;
                end
                S_SC_ACC: begin
                    r_o[r_cnt[2:1]] <= r_o[r_cnt[2:1]] + w_term;
                    if (r_cnt == 3'd5) begin
                        r_idx   <= '0;
                        r_state <= S_EM_RD;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_SC_MUL;
                    end
                end
                S_EM_RD: r_state <= S_EM_CAP;
                S_EM_CAP: begin
                    r_qx     <= sat32($signed(OW'($signed(r_rd_x))) + r_o[0]);
                    r_qy     <= sat32($signed(OW'($signed(r_rd_y))) + r_o[1]);
                    r_qz     <= sat32($signed(OW'($signed(r_rd_z))) + r_o[2]);
                    r_inv    <= 1'b0;
                    r_last   <= ((CW'(r_idx) + 1'b1) == r_n);
                    r_ovalid <= 1'b1;
                    r_state  <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    if (o_res.ready) begin
                        r_ovalid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.qx          = r_qx;
    assign o_res.qy          = r_qy;
    assign o_res.qz          = r_qz;
    assign o_res.invalid     = r_inv;
    assign o_res.last_result = r_last;

endmodule

>>> hw/rtl/waypoint_frenet_offset_translate.sv
// Top level of the waypoint Frenet offset translator: register file, front end,
// command queue and back end. Depends on wfot_pkg, wfot_if and the wfot_* modules.
//
//   Channel  Direction  Beat
//   i_pt     in         one waypoint (px, py, pz, last_point)
//   o_res    out        one translated point (qx, qy, qz, invalid, last_result)
//   i_cfg    in         one register write (idx, wdata); always ready
//
// Waypoints are taken one a cycle while the queue has room; a beat with last_point
// starts a run in the back end, which holds further beats in the queue until it ends.
// A run normalises the segment with shifts, takes its length with the serial square
// root and divides by it serially; a zero-length segment skips to the scaling.
// Each result is read from the store, offset and saturated, then registered for output.
// Results wait in the output register while the sink stalls.
// Reset clears the point count, the registers and all handshake state.
module waypoint_frenet_offset_translate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wfot_pt_if.sink     i_pt,
    wfot_res_if.source  o_res,
    wfot_cfg_if.sink    i_cfg
);
    import wfot_pkg::*;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_OFFSET_S:  r_cfg.offset_s  <= i_cfg.wdata;
                CFG_OFFSET_D:  r_cfg.offset_d  <= i_cfg.wdata;
                CFG_REF_INDEX: r_cfg.ref_index <= i_cfg.wdata[5:0];
                default: ;
            endcase
        end
    end

    wfot_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_cmd   (w_front_cmd),
        .o_push  (w_push),
        .i_full  (w_full)
    );

    wfot_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    wfot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_queue_cmd),
        .i_cmd_valid (!w_empty),
        .o_cmd_pop   (w_pop),
        .i_cfg       (r_cfg),
        .o_res       (o_res)
    );

endmodule
